// ===== rtl/ems_pkg.sv =====
// Package: shared types and constants of the edge midpoint subdivider.
`timescale 1ns / 1ps
package ems_pkg;
	localparam int CORNER_W     = 10;
	localparam int FIELD_W      = 16;
	localparam int TAG_W        = 8;
	localparam int BUCKET_COUNT = 1024;
	localparam int BKT_W        = 10;

	localparam logic       KIND_MID   = 1'b0;
	localparam logic       KIND_TRI   = 1'b1;
	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_FULL = 2'd1;
	localparam logic [1:0] FAULT_EXH  = 2'd2;

	typedef struct packed {
		logic                 live;
		logic [TAG_W-1:0]     tag;
		logic [FIELD_W-1:0]   high;
		logic [FIELD_W-1:0]   index;
	} edge_entry_t;

	localparam int ENTRY_W = $bits(edge_entry_t);

	// one classified triangle: corners plus each of its edges in low/high order
	typedef struct packed {
		logic [2:0][CORNER_W-1:0] corner;
		logic [2:0][CORNER_W-1:0] lo;
		logic [2:0][CORNER_W-1:0] hi;
		logic                     first;
	} tri_item_t;

	typedef struct packed {
		logic      valid;
		tri_item_t item;
	} queue_out_t;
endpackage

// ===== rtl/ems_ram.sv =====
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
module ems_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ems_front.sv =====
// Front end: accepts triangles, orders edge ends, holds them in a two-entry queue.
`timescale 1ns / 1ps
module ems_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ems_pkg::CORNER_W-1:0]  corner_a,
	input  logic [ems_pkg::CORNER_W-1:0]  corner_b,
	input  logic [ems_pkg::CORNER_W-1:0]  corner_c,
	input  logic                          first_of_mesh,
	input  logic                          clearing,
	input  logic                          pop,
	output logic                          busy,
	output ems_pkg::queue_out_t           q_out
);
	import ems_pkg::*;

	tri_item_t   q_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	tri_item_t   item;
	logic        push;

	always_comb begin
		item.corner[0] = corner_a;
		item.corner[1] = corner_b;
		item.corner[2] = corner_c;
		item.first     = first_of_mesh;
		// edges (a,b), (b,c), (a,c), each low end first
		item.lo[0] = (corner_b < corner_a) ? corner_b : corner_a;
		item.hi[0] = (corner_b < corner_a) ? corner_a : corner_b;
		item.lo[1] = (corner_c < corner_b) ? corner_c : corner_b;
		item.hi[1] = (corner_c < corner_b) ? corner_b : corner_c;
		item.lo[2] = (corner_c < corner_a) ? corner_c : corner_a;
		item.hi[2] = (corner_c < corner_a) ? corner_a : corner_c;
	end

	assign busy        = (cnt_q == 2'd2) || clearing;
	assign push        = start && !busy;
	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.item  = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/ems_back.sv =====
// Back end: edge table lookups, index assignment and result sequencing.
`timescale 1ns / 1ps
module ems_back #(
	parameter int VERTEX_LIMIT = 1024,
	parameter int BUCKET_SLOTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ems_pkg::queue_out_t           q_out,
	input  logic [ems_pkg::FIELD_W-1:0]   base_q,
	output logic                          pop,
	output logic                          clearing,
	output logic                          strobe,
	output logic                          record_kind,
	output logic [ems_pkg::FIELD_W-1:0]   slot_one,
	output logic [ems_pkg::FIELD_W-1:0]   slot_two,
	output logic [ems_pkg::FIELD_W-1:0]   slot_three,
	output logic [1:0]                    fault,
	output logic                          last_of_run
);
	import ems_pkg::*;

	localparam int ROW_W  = BUCKET_SLOTS * ENTRY_W;
	localparam int SLOT_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int NV_W   = FIELD_W + 1;

	typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_RD, S_LOOK, S_TRI} st_t;

	st_t                     st_q;
	logic [BKT_W-1:0]        clr_q;
	logic                    run_q;
	tri_item_t               item_q;
	logic [1:0]              e_q;
	logic [1:0]              tri_q;
	logic [TAG_W-1:0]        tag_q;
	logic [NV_W-1:0]         nv_q;
	logic [FIELD_W-1:0]      mid_q [3];
	logic                    strobe_q, kind_q, last_q;
	logic [FIELD_W-1:0]      s1_q, s2_q, s3_q;
	logic [1:0]              fault_q;

	logic [ROW_W-1:0]        rd_row, wr_row;
	logic                    ram_we;
	logic [BKT_W-1:0]        ram_waddr;
	logic [CORNER_W-1:0]     cur_lo, cur_hi;
	logic                    found, free_ok, exh;
	logic [FIELD_W-1:0]      hit_idx, new_idx;
	logic [SLOT_W-1:0]       free_slot;
	logic [1:0]              new_fault;
	logic [TAG_W-1:0]        tag_n;
	edge_entry_t             ent, new_ent;

	always_comb begin
		unique case (e_q)
			2'd0:    begin cur_lo = item_q.lo[0]; cur_hi = item_q.hi[0]; end
			2'd1:    begin cur_lo = item_q.lo[1]; cur_hi = item_q.hi[1]; end
			2'd2:    begin cur_lo = item_q.lo[2]; cur_hi = item_q.hi[2]; end
			default: begin cur_lo = item_q.lo[0]; cur_hi = item_q.hi[0]; end
		endcase
	end

	// search the bucket: first live match, else first dead or stale slot
	always_comb begin
		found     = 1'b0;
		free_ok   = 1'b0;
		hit_idx   = '0;
		free_slot = '0;
		ent       = '0;
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			ent = rd_row[s*ENTRY_W +: ENTRY_W];
			if (ent.live && ent.tag == tag_q && !found
				&& ent.high == FIELD_W'(cur_hi)) begin
				found   = 1'b1;
				hit_idx = ent.index;
			end else if (!(ent.live && ent.tag == tag_q) && !free_ok) begin
				free_ok   = 1'b1;
				free_slot = SLOT_W'(s);
			end
		end
	end

	assign exh     = (nv_q >= NV_W'(VERTEX_LIMIT));
	assign new_idx = exh ? FIELD_W'(VERTEX_LIMIT - 1) : nv_q[FIELD_W-1:0];
	assign new_fault = exh ? FAULT_EXH : (free_ok ? FAULT_NONE : FAULT_FULL);

	always_comb begin
		new_ent.live  = 1'b1;
		new_ent.tag   = tag_q;
		new_ent.high  = FIELD_W'(cur_hi);
		new_ent.index = new_idx;
		wr_row        = rd_row;
		wr_row[free_slot*ENTRY_W +: ENTRY_W] = new_ent;
		if (st_q == S_CLEAR) begin
			wr_row = '0;
		end
	end

	assign ram_we    = (st_q == S_CLEAR) || (st_q == S_LOOK && !found && free_ok);
	assign ram_waddr = (st_q == S_CLEAR) ? clr_q : cur_lo;
	assign tag_n     = tag_q + TAG_W'(1);

	ems_ram #(.WIDTH(ROW_W), .DEPTH(BUCKET_COUNT)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_row),
		.raddr (cur_lo),
		.rdata (rd_row)
	);

	assign pop      = (st_q == S_IDLE) && q_out.valid;
	assign clearing = (st_q == S_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			clr_q    <= '0;
			run_q    <= 1'b0;
			e_q      <= '0;
			tri_q    <= '0;
			tag_q    <= '0;
			nv_q     <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_out.valid) begin
						item_q <= q_out.item;
						e_q    <= '0;
						st_q   <= S_RD;
						if (q_out.item.first) begin
							tag_q <= tag_n;
							nv_q  <= NV_W'(base_q);
							if (tag_n == '0) begin
								st_q  <= S_CLEAR;
								clr_q <= '0;
								run_q <= 1'b1;
							end
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKET_COUNT - 1)) begin
						st_q  <= run_q ? S_RD : S_IDLE;
						run_q <= 1'b0;
					end
				end
				S_RD: begin
					st_q <= S_LOOK;
				end
				S_LOOK: begin
					if (found) begin
						mid_q[e_q] <= hit_idx;
					end else begin
						mid_q[e_q] <= new_idx;
						if (!exh) begin
							nv_q <= nv_q + NV_W'(1);
						end
						strobe_q <= 1'b1;
						kind_q   <= KIND_MID;
						s1_q     <= FIELD_W'(cur_lo);
						s2_q     <= FIELD_W'(cur_hi);
						s3_q     <= new_idx;
						fault_q  <= new_fault;
					end
					if (e_q == 2'd2) begin
						st_q  <= S_TRI;
						tri_q <= '0;
					end else begin
						e_q  <= e_q + 2'd1;
						st_q <= S_RD;
					end
				end
				S_TRI: begin
					strobe_q <= 1'b1;
					kind_q   <= KIND_TRI;
					fault_q  <= FAULT_NONE;
					tri_q    <= tri_q + 2'd1;
					unique case (tri_q)
						2'd0: begin
							s1_q <= FIELD_W'(item_q.corner[0]);
							s2_q <= mid_q[0];
							s3_q <= mid_q[2];
						end
						2'd1: begin
							s1_q <= mid_q[0];
							s2_q <= FIELD_W'(item_q.corner[1]);
							s3_q <= mid_q[1];
						end
						2'd2: begin
							s1_q <= mid_q[2];
							s2_q <= mid_q[1];
							s3_q <= FIELD_W'(item_q.corner[2]);
						end
						default: begin
							s1_q   <= mid_q[2];
							s2_q   <= mid_q[0];
							s3_q   <= mid_q[1];
							last_q <= 1'b1;
							st_q   <= S_IDLE;
						end
					endcase
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign record_kind = kind_q;
	assign slot_one    = s1_q;
	assign slot_two    = s2_q;
	assign slot_three  = s3_q;
	assign fault       = fault_q;
	assign last_of_run = last_q;

`ifndef ASSERT_OFF
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ($past(st_q) == S_LOOK || $past(st_q) == S_TRI))
		else $error("result strobe without a producing state");
	a_last_tri: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> (strobe_q && kind_q == KIND_TRI))
		else $error("last_of_run on a non-triangle record");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLEAR) |=> !strobe_q)
		else $error("result emitted during table clear");
`endif
endmodule

// ===== rtl/edge_midpoint_subdivider.sv =====
// Top level: 1-to-4 midpoint triangle subdivider with edge table.
`timescale 1ns / 1ps
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------
//  input     | start & !busy         | corner_a, corner_b, corner_c, first_of_mesh
//  result    | strobe (one cycle)    | record_kind, slot_one/two/three, fault,
//            |                       | last_of_run
//  config    | cfg_we                | cfg_wdata (base_vertex_count)
//
// In the back end a triangle passes S_IDLE, then S_RD (table read) and S_LOOK
// (compare and update) for each edge, then S_TRI for its four triangle records;
// the single edge table read port paces it. Two classified triangles can wait in the
// queue between front and back. After reset, and when the mesh tag wraps to zero,
// the table is swept one bucket per cycle, and busy stays high throughout the sweep.
// The receiver cannot stall: each result transfer lasts exactly one strobe cycle.
module edge_midpoint_subdivider #(
	parameter int VERTEX_LIMIT = 1024,
	parameter int BUCKET_SLOTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [9:0]   corner_a,
	input  logic [9:0]   corner_b,
	input  logic [9:0]   corner_c,
	input  logic         first_of_mesh,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	output logic         strobe,
	output logic         record_kind,
	output logic [15:0]  slot_one,
	output logic [15:0]  slot_two,
	output logic [15:0]  slot_three,
	output logic [1:0]   fault,
	output logic         last_of_run
);
	import ems_pkg::*;

	// hold the register; the user must write it only while idle (the block does not enforce this)
	logic [FIELD_W-1:0] base_q;
	queue_out_t         q_out;
	logic               pop, clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// classify and queue incoming triangles
	ems_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.first_of_mesh (first_of_mesh),
		.clearing      (clearing),
		.pop           (pop),
		.busy          (busy),
		.q_out         (q_out)
	);

	// advance each queued triangle through lookups and result transfers
	ems_back #(.VERTEX_LIMIT(VERTEX_LIMIT), .BUCKET_SLOTS(BUCKET_SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_out       (q_out),
		.base_q      (base_q),
		.pop         (pop),
		.clearing    (clearing),
		.strobe      (strobe),
		.record_kind (record_kind),
		.slot_one    (slot_one),
		.slot_two    (slot_two),
		.slot_three  (slot_three),
		.fault       (fault),
		.last_of_run (last_of_run)
	);
endmodule
